>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the line sensor position estimator RTL.
// Each macro samples on posedge clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge out of reset
`define LSPE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Expression must never be true out of reset
`define LSPE_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");

`else

`define LSPE_ASSERT(label, prop)
`define LSPE_NEVER(label, expr)

`endif

`endif

>>> rtl/lspe_pkg.sv
// ----------------------------------------------------------------------------
// lspe_pkg
// Shared widths, constants, register codes, controller states and the
// command/status bundles of the line sensor position estimator.
// ----------------------------------------------------------------------------
package lspe_pkg;

    // Field and register widths
    localparam int IDX_W     = 4;
    localparam int RAW_W     = 12;
    localparam int CENTER_W  = 14;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 14;
    localparam int ERR_W     = 15;
    localparam int WACC_W    = 27;
    localparam int RACC_W    = 14;

    // Sensor array and scaling constants
    localparam int SENSOR_COUNT   = 16;
    localparam int FIRST_WEIGHTED = 2;
    localparam int LAST_WEIGHTED  = 13;
    localparam int FULL_SCALE     = 1000;
    localparam int SAMPLE_BITS    = 12;

    // Register reset values
    localparam logic [RAW_W-1:0]    RAW_LOW_RESET  = RAW_W'(0);
    localparam logic [RAW_W-1:0]    RAW_HIGH_RESET = RAW_W'(4095);
    localparam logic [CENTER_W-1:0] CENTER_RESET   = CENTER_W'(5500);

    // Derived widths
    localparam int READ_W      = $clog2(FULL_SCALE + 1);
    localparam int PROD_W      = RAW_W + READ_W;
    localparam int WT_MAX      = (LAST_WEIGHTED - FIRST_WEIGHTED) * FULL_SCALE;
    localparam int WT_W        = $clog2(WT_MAX + 1);
    localparam int WPROD_W     = READ_W + WT_W;
    localparam int DIV_CNT_W   = $clog2(WACC_W + 1);
    localparam int SCALE_SHIFT = WACC_W - PROD_W;

    localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    // Configuration register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RAW_LOW  = 2'd0,
        REG_RAW_HIGH = 2'd1,
        REG_CENTER   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [RAW_W-1:0]    raw_low;
        logic [RAW_W-1:0]    raw_high;
        logic [CENTER_W-1:0] center;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_MUL,
        ST_ACC,
        ST_FRAME,
        ST_FDIV,
        ST_RESULT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scale_direct;
        logic scale_start;
        logic scale_take;
        logic mul;
        logic acc;
        logic frame_start;
        logic result;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic weighted;
        logic window_empty;
        logic last;
        logic div_done;
        logic acc_zero;
    } status_t;

    // Weight of a central sensor: (index - first) * full scale
    function automatic logic [WT_W-1:0] weight_of(input logic [IDX_W-1:0] idx);
        return WT_W'((int'(idx) - FIRST_WEIGHTED) * FULL_SCALE);
    endfunction

endpackage

>>> rtl/lspe_divider.sv
// ----------------------------------------------------------------------------
// lspe_divider
// Restoring divider, one quotient bit per cycle. The numerator is loaded
// left-aligned and steps bits are retired; the quotient lands in the low
// steps bits of quo. done pulses for one cycle, quo holds until next start.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lspe_divider #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 14,
    parameter int CNT_W = $clog2(NUM_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [CNT_W-1:0] steps,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] count_reg;
    logic             run_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;
    logic             fits;

    // Trial subtract of the shifted partial remainder
    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, trial} - {2'b00, den_reg};
        fits     = ~diff[DEN_W+1];
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // Payload: load on start, shift while running
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                count_reg <= steps;
                run_reg   <= 1'b1;
            end
            else if (run_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    `LSPE_ASSERT(a_run_has_steps, run_reg |-> (count_reg != '0))
    `LSPE_NEVER(a_done_while_running, done_reg && run_reg)

endmodule

>>> rtl/lspe_cfg_regs.sv
// ----------------------------------------------------------------------------
// lspe_cfg_regs
// Calibration window and centre registers, written through the plain
// write port. Writes to an unused index are dropped.
// ----------------------------------------------------------------------------
module lspe_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [lspe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lspe_pkg::CFG_W-1:0]     cfg_data,
    output lspe_pkg::cfg_t                 cfg
);

    import lspe_pkg::*;

    cfg_t cfg_reg;

    // Decode the index and store the masked data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.raw_low  <= RAW_LOW_RESET;
            cfg_reg.raw_high <= RAW_HIGH_RESET;
            cfg_reg.center   <= CENTER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RAW_LOW:  cfg_reg.raw_low  <= cfg_data[RAW_W-1:0];
                REG_RAW_HIGH: cfg_reg.raw_high <= cfg_data[RAW_W-1:0];
                REG_CENTER:   cfg_reg.center   <= cfg_data[CENTER_W-1:0];
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lspe_datapath.sv
// ----------------------------------------------------------------------------
// lspe_datapath
// Sample capture, window clamp and scale, weighting multiply, saturating
// accumulators, the shared divider and the result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lspe_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lspe_pkg::cmd_t                  cmd,
    output lspe_pkg::status_t               status,
    input  lspe_pkg::cfg_t                  cfg,
    input  logic [lspe_pkg::IDX_W-1:0]      sensor_index,
    input  logic [lspe_pkg::RAW_W-1:0]      raw_sample,
    input  logic                            frame_last,
    output logic                            result_valid,
    output logic [lspe_pkg::POS_W-1:0]      line_position,
    output logic signed [lspe_pkg::ERR_W-1:0] position_error,
    output logic                            no_line
);

    import lspe_pkg::*;

    // Captured transaction
    logic [IDX_W-1:0]   idx_reg;
    logic [RAW_W-1:0]   raw_reg;
    logic               last_reg;

    logic [READ_W-1:0]  reading_reg;
    logic [WPROD_W-1:0] wprod_reg;
    logic [WACC_W-1:0]  wacc_reg;
    logic [WACC_W-1:0]  wacc_next;
    logic [RACC_W-1:0]  racc_reg;
    logic [RACC_W-1:0]  racc_next;
    logic [POS_W-1:0]   held_reg;
    logic               valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic               none_reg;

    logic [RAW_W-1:0]   raw_m;
    logic [RAW_W-1:0]   raw_c;
    logic [RAW_W-1:0]   span;
    logic [PROD_W-1:0]  scale_prod;
    logic               window_empty;
    logic               weighted;
    logic [READ_W-1:0]  reading_direct;
    logic [READ_W-1:0]  reading_div;

    logic               div_start;
    logic [WACC_W-1:0]  div_num;
    logic [RACC_W-1:0]  div_den;
    logic [DIV_CNT_W-1:0] div_steps;
    logic               div_done;
    logic [WACC_W-1:0]  div_quo;

    logic [WACC_W:0]    wacc_sum;
    logic [RACC_W:0]    racc_sum;
    logic               acc_zero;
    logic [POS_W-1:0]   pos_frame;
    logic [POS_W-1:0]   pos_sel;

    // Clamp the sample into the calibrated window and form the numerator
    always_comb
    begin
        raw_m        = raw_reg & SAMPLE_MASK;
        window_empty = (cfg.raw_high <= cfg.raw_low);
        if (raw_m < cfg.raw_low)
            raw_c = cfg.raw_low;
        else if (raw_m > cfg.raw_high)
            raw_c = cfg.raw_high;
        else
            raw_c = raw_m;
        span           = cfg.raw_high - cfg.raw_low;
        scale_prod     = PROD_W'(raw_c - cfg.raw_low) * PROD_W'(FULL_SCALE);
        reading_direct = (raw_m > cfg.raw_low) ? '0 : READ_W'(FULL_SCALE);
        reading_div    = READ_W'(FULL_SCALE) - div_quo[READ_W-1:0];
        weighted       = (int'(idx_reg) >= FIRST_WEIGHTED) &&
                         (int'(idx_reg) <= LAST_WEIGHTED) &&
                         (int'(idx_reg) < SENSOR_COUNT);
    end

    // Share the divider between sample scaling and the frame average
    always_comb
    begin
        div_start = cmd.scale_start | cmd.frame_start;
        if (cmd.frame_start)
        begin
            div_num   = wacc_reg;
            div_den   = racc_reg;
            div_steps = DIV_CNT_W'(WACC_W);
        end
        else
        begin
            div_num   = WACC_W'(scale_prod) << SCALE_SHIFT;
            div_den   = RACC_W'(span);
            div_steps = DIV_CNT_W'(PROD_W);
        end
    end

    lspe_divider #(
        .NUM_W (WACC_W),
        .DEN_W (RACC_W),
        .CNT_W (DIV_CNT_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Saturating accumulate and frame result selection
    always_comb
    begin
        wacc_sum  = {1'b0, wacc_reg} + (WACC_W+1)'(wprod_reg);
        racc_sum  = {1'b0, racc_reg} + (RACC_W+1)'(reading_reg);
        acc_zero  = (racc_reg == '0);
        pos_frame = (|div_quo[WACC_W-1:POS_W]) ? '1 : div_quo[POS_W-1:0];
        pos_sel   = acc_zero ? held_reg : pos_frame;
        wacc_next = wacc_reg;
        racc_next = racc_reg;
        if (cmd.acc)
        begin
            wacc_next = wacc_sum[WACC_W] ? '1 : wacc_sum[WACC_W-1:0];
            racc_next = racc_sum[RACC_W] ? '1 : racc_sum[RACC_W-1:0];
        end
        else if (cmd.result)
        begin
            wacc_next = '0;
            racc_next = '0;
        end
    end

    // Payload: capture, reading, weighted product, result fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            idx_reg  <= sensor_index;
            raw_reg  <= raw_sample;
            last_reg <= frame_last;
        end
        if (cmd.scale_direct)
            reading_reg <= reading_direct;
        else if (cmd.scale_take)
            reading_reg <= reading_div;
        if (cmd.mul)
            wprod_reg <= WPROD_W'(reading_reg) * WPROD_W'(weight_of(idx_reg));
        if (cmd.result)
        begin
            pos_reg  <= pos_sel;
            err_reg  <= signed'(ERR_W'(pos_sel) - ERR_W'(cfg.center));
            none_reg <= acc_zero;
        end
    end

    // Frame state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wacc_reg  <= '0;
            racc_reg  <= '0;
            held_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            wacc_reg  <= wacc_next;
            racc_reg  <= racc_next;
            valid_reg <= cmd.result;
            if (cmd.result)
                held_reg <= pos_sel;
        end
    end

    assign status.weighted     = weighted;
    assign status.window_empty = window_empty;
    assign status.last         = last_reg;
    assign status.div_done     = div_done;
    assign status.acc_zero     = acc_zero;

    assign result_valid   = valid_reg;
    assign line_position  = pos_reg;
    assign position_error = err_reg;
    assign no_line        = none_reg;

    `LSPE_ASSERT(a_result_matches_held, valid_reg |-> (pos_reg == held_reg))
    `LSPE_ASSERT(a_frame_cleared, valid_reg |-> (wacc_reg == '0 && racc_reg == '0))

endmodule

>>> rtl/lspe_ctrl.sv
// ----------------------------------------------------------------------------
// lspe_ctrl
// Sequencer for one transaction: capture, scale, weight, accumulate and,
// on the last sample of a frame, divide and publish the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lspe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lspe_pkg::status_t status,
    output lspe_pkg::cmd_t    cmd
);

    import lspe_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance the sequence and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.weighted)
                begin
                    if (status.window_empty)
                    begin
                        cmd.scale_direct = 1'b1;
                        state_next       = ST_MUL;
                    end
                    else
                    begin
                        cmd.scale_start = 1'b1;
                        state_next      = ST_SCALE;
                    end
                end
                else
                    state_next = status.last ? ST_FRAME : ST_IDLE;
            end
            ST_SCALE:
            begin
                if (status.div_done)
                begin
                    cmd.scale_take = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last ? ST_FRAME : ST_IDLE;
            end
            ST_FRAME:
            begin
                if (status.acc_zero)
                    state_next = ST_RESULT;
                else
                begin
                    cmd.frame_start = 1'b1;
                    state_next      = ST_FDIV;
                end
            end
            ST_FDIV:
            begin
                if (status.div_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                cmd.result = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    `LSPE_ASSERT(a_busy_from_start, $rose(busy) |-> $past(start))
    `LSPE_ASSERT(a_done_when_waiting,
        status.div_done |-> (state_reg == ST_SCALE || state_reg == ST_FDIV))

endmodule

>>> rtl/line_sensor_position_estimator.sv
// ----------------------------------------------------------------------------
// line_sensor_position_estimator
// Weighted-average line position from a stream of tagged infrared sensor
// samples, with error against a configurable centre.
//
//   Channel  Handshake             Payload
//   -------  --------------------  ---------------------------------------
//   sample   start / busy          sensor_index, raw_sample, frame_last
//   result   result_valid strobe   line_position, position_error, no_line
//   config   cfg_write             cfg_index, cfg_data
//
// A sample from an unweighted sensor is only captured and checked. A weighted
// sample is scaled into the window by the shared divider in 22 one-bit steps
// (bypassed when the window is empty), then weighted and accumulated.
// The last sample of a frame then divides the sums for the average in 27
// divider steps (skipped when the reading sum is zero); result_valid rises at
// the same edge at which busy drops.
// Reset clears the accumulators and held position and loads the register
// defaults. The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module line_sensor_position_estimator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lspe_pkg::IDX_W-1:0]        sensor_index,
    input  logic [lspe_pkg::RAW_W-1:0]        raw_sample,
    input  logic                              frame_last,
    output logic                              result_valid,
    output logic [lspe_pkg::POS_W-1:0]        line_position,
    output logic signed [lspe_pkg::ERR_W-1:0] position_error,
    output logic                              no_line,
    input  logic                              cfg_write,
    input  logic [lspe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lspe_pkg::CFG_W-1:0]        cfg_data
);

    import lspe_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    lspe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lspe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    lspe_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .sensor_index   (sensor_index),
        .raw_sample     (raw_sample),
        .frame_last     (frame_last),
        .result_valid   (result_valid),
        .line_position  (line_position),
        .position_error (position_error),
        .no_line        (no_line)
    );

endmodule
